>>> rtl/p1mg_pkg.sv
// ----------------------------------------------------------------------------
// p1mg_pkg: shared types and constants
// Request codes, configuration indexes, the sequencer control struct and
// a saturation helper for the 1D Poisson multigrid solver.
// ----------------------------------------------------------------------------
`default_nettype none
package p1mg_pkg;

  localparam logic [1:0] ReqLoad = 2'd0;
  localparam logic [1:0] ReqRun  = 2'd1;
  localparam logic [1:0] ReqRead = 2'd2;

  localparam logic [1:0] CfgScale = 2'd0;
  localparam logic [1:0] CfgLeft  = 2'd1;
  localparam logic [1:0] CfgRight = 2'd2;

  localparam logic signed [31:0] RightReset = 32'sd6553600;

  // Operation that the sequencer asks the datapath to perform on one point.
  typedef enum logic [2:0] {
    OpNone,
    OpSmooth,
    OpRestrict,
    OpProlEven,
    OpProlOdd
  } op_e;

  // Sequencer to datapath control for one point update.
  typedef struct packed {
    logic        vld;
    op_e         op;
    logic [10:0] base;
    logic [10:0] cbase;
    logic [10:0] ncells;
    logic [10:0] ccells;
    logic [10:0] j;
  } step_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/p1mg_if.sv
// ----------------------------------------------------------------------------
// p1mg_req_if / p1mg_rsp_if: request and response channels
// Valid/ready channels carrying the solver's request and result fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface p1mg_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [8:0]         point_index;
  logic [31:0]        electron_density;
  logic [31:0]        ion_density;
  logic signed [31:0] start_potential;
  logic [7:0]         cycle_count;
  modport source (output valid, req_type, point_index, electron_density, ion_density,
                  start_potential, cycle_count, input ready);
  modport sink (input valid, req_type, point_index, electron_density, ion_density,
                start_potential, cycle_count, output ready);
endinterface

interface p1mg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] potential;
  logic [8:0]         result_index;
  logic               solve_done;
  modport source (output valid, potential, result_index, solve_done, input ready);
  modport sink (input valid, potential, result_index, solve_done, output ready);
endinterface
`default_nettype wire

>>> rtl/p1mg_src.sv
// ----------------------------------------------------------------------------
// p1mg_src: source term unit
// Two-stage multiply that turns a neighbour charge sum into a scaled,
// negated and saturated Q16.16 source value.
// ----------------------------------------------------------------------------
`default_nettype none
module p1mg_src (
  input  wire logic               clk_i,
  input  wire logic               start_i,
  input  wire logic signed [33:0] sum_i,
  input  wire logic [31:0]        scale_i,
  output logic signed [31:0]      src_o
);
  logic        neg_q, neg_d;
  logic [33:0] mag_q, mag_d;
  logic [15:0] rh_q, rl_q;
  logic [49:0] ph_q;
  logic [49:0] pl_q;
  logic        neg2_q;
  logic [50:0] q;

  always_comb begin
    neg_d = sum_i[33];
    mag_d = neg_d ? 34'(-sum_i) : 34'(sum_i);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
      rh_q  <= scale_i[31:16];
      rl_q  <= scale_i[15:0];
    end
    ph_q   <= 50'(mag_q) * 50'(rh_q);
    pl_q   <= 50'(mag_q) * 50'(rl_q);
    neg2_q <= neg_q;
  end

  always_comb begin
    q = 51'(ph_q) + 51'(pl_q[49:16]);
    if (neg2_q) begin
      src_o = (q > 51'd2147483647) ? 32'sh7FFF_FFFF : signed'(q[31:0]);
    end else begin
      src_o = (q >= 51'd2147483648) ? 32'sh8000_0000 : signed'(32'(-q[31:0]));
    end
  end
endmodule
`default_nettype wire

>>> rtl/p1mg_seq.sv
// ----------------------------------------------------------------------------
// p1mg_seq: V-cycle sequencer
// Walks levels, phases, sweeps and points of each V-cycle and issues one
// point operation at a time when the datapath asks for the next one.
// ----------------------------------------------------------------------------
`default_nettype none
module p1mg_seq #(
  parameter int GRID_CELLS    = 256,
  parameter int LEVELS        = 6,
  parameter int SMOOTH_SWEEPS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [7:0]  cycles_i,
  input  wire logic        next_i,
  output p1mg_pkg::step_t  step_o,
  output logic             done_o
);
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhDown = 3'd1;
  localparam logic [2:0] PhRes  = 3'd2;
  localparam logic [2:0] PhBot  = 3'd3;
  localparam logic [2:0] PhProl = 3'd4;
  localparam logic [2:0] PhUp   = 3'd5;
  localparam logic [2:0] PhFin  = 3'd6;
  localparam int CoarseSweeps = 3 * SMOOTH_SWEEPS;

  logic [2:0]  ph_q, ph_d;
  logic [3:0]  lvl_q, lvl_d;
  logic [4:0]  sw_q, sw_d;
  logic [10:0] j_q, j_d;
  logic        odd_q, odd_d;
  logic [7:0]  cyc_q, cyc_d;
  logic [10:0] nc, cc, bs, cbs, hn;

  function automatic logic [10:0] lbase(input logic [3:0] n);
    logic [10:0] b;
    b = '0;
    for (int k = 0; k < 9; k++) begin
      if (4'(k) < n) b = b + 11'((GRID_CELLS >> k) + 1);
    end
    return b;
  endfunction

  always_comb begin
    nc  = 11'(GRID_CELLS) >> lvl_q;
    cc  = 11'(GRID_CELLS) >> (lvl_q + 4'd1);
    bs  = lbase(lvl_q);
    cbs = lbase(lvl_q + 4'd1);
    hn  = nc >> 1;
  end

  always_comb begin
    ph_d  = ph_q;
    lvl_d = lvl_q;
    sw_d  = sw_q;
    j_d   = j_q;
    odd_d = odd_q;
    cyc_d = cyc_q;
    step_o        = '0;
    step_o.base   = bs;
    step_o.cbase  = cbs;
    step_o.ncells = nc;
    step_o.ccells = cc;
    step_o.j      = j_q;
    done_o = 1'b0;
    case (ph_q)
      PhIdle: begin
        if (start_i) begin
          cyc_d = cycles_i;
          lvl_d = '0;
          sw_d  = '0;
          j_d   = 11'd1;
          ph_d  = (cycles_i == 8'd0) ? PhFin : PhDown;
        end
      end
      PhDown, PhBot, PhUp: begin
        if (nc < 11'd2) begin
          j_d = 11'd1;
          sw_d = '0;
          if (ph_q == PhDown) ph_d = PhRes;
          else if (ph_q == PhBot) ph_d = (LEVELS == 0) ? PhFin : PhProl;
          else ph_d = PhFin;
          if (ph_q == PhBot) lvl_d = 4'(LEVELS - 1);
          if (ph_q == PhUp && lvl_q != 4'd0) begin
            lvl_d = lvl_q - 4'd1;
            ph_d = PhProl;
          end
        end else begin
          step_o.vld = 1'b1;
          step_o.op  = p1mg_pkg::OpSmooth;
          if (next_i) begin
            if (j_q + 11'd1 < nc) begin
              j_d = j_q + 11'd1;
            end else begin
              j_d = 11'd1;
              if (5'(sw_q + 5'd1) < ((ph_q == PhBot) ? 5'(CoarseSweeps) : 5'(SMOOTH_SWEEPS)))
              begin
                sw_d = sw_q + 5'd1;
              end else begin
                sw_d = '0;
                if (ph_q == PhDown) ph_d = PhRes;
                else if (ph_q == PhBot) begin
                  lvl_d = 4'(LEVELS - 1);
                  ph_d = PhProl;
                end else if (lvl_q != 4'd0) begin
                  lvl_d = lvl_q - 4'd1;
                  ph_d = PhProl;
                end else ph_d = PhFin;
              end
            end
          end
        end
      end
      PhRes: begin
        if (((j_q << (lvl_q + 4'd1)) < 11'(GRID_CELLS)) && (j_q <= cc)) begin
          step_o.vld = 1'b1;
          step_o.op  = p1mg_pkg::OpRestrict;
          if (next_i) j_d = j_q + 11'd1;
        end else begin
          j_d   = 11'd1;
          lvl_d = lvl_q + 4'd1;
          ph_d  = (lvl_q + 4'd1 == 4'(LEVELS)) ? PhBot : PhDown;
        end
      end
      PhProl: begin
        if (j_q < hn) begin
          step_o.vld = 1'b1;
          step_o.op  = odd_q ? p1mg_pkg::OpProlOdd : p1mg_pkg::OpProlEven;
          step_o.j   = odd_q ? 11'((j_q << 1) - 11'd1) : 11'(j_q << 1);
          if (next_i) begin
            odd_d = ~odd_q;
            if (odd_q) j_d = j_q + 11'd1;
          end
        end else if (hn >= 11'd1 && !odd_q) begin
          step_o.vld = 1'b1;
          step_o.op  = p1mg_pkg::OpProlOdd;
          step_o.j   = 11'((hn << 1) - 11'd1);
          if (next_i) odd_d = 1'b1;
        end else begin
          odd_d = 1'b0;
          j_d   = 11'd1;
          sw_d  = '0;
          ph_d  = PhUp;
        end
      end
      PhFin: begin
        if (cyc_q > 8'd1) begin
          cyc_d = cyc_q - 8'd1;
          lvl_d = '0;
          j_d   = 11'd1;
          ph_d  = PhDown;
        end else begin
          done_o = 1'b1;
          ph_d = PhIdle;
        end
      end
      default: ph_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhIdle;
      lvl_q <= '0;
      sw_q  <= '0;
      j_q   <= 11'd1;
      odd_q <= 1'b0;
      cyc_q <= '0;
    end else begin
      ph_q  <= ph_d;
      lvl_q <= lvl_d;
      sw_q  <= sw_d;
      j_q   <= j_d;
      odd_q <= odd_d;
      cyc_q <= cyc_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/poisson_1d_multigrid_solver.sv
// ----------------------------------------------------------------------------
// poisson_1d_multigrid_solver: 1D Poisson multigrid V-cycle solver
// Load items pass through StLoad, StLoad2 and StLoad3, read items through StRead
// to a result; a run takes every point update of every sweep, restriction and
// prolongation through StRun, StRd0 to StRd3 and StWr, set by the single read
// port of each memory. After reset a clearing pass over all 2*GRID_CELLS+LEVELS+1
// entries zeroes both memories before the first item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module poisson_1d_multigrid_solver #(
  parameter int GRID_CELLS    = 256,
  parameter int LEVELS        = 6,
  parameter int SMOOTH_SWEEPS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  p1mg_req_if.sink         req,
  p1mg_rsp_if.source       rsp
);
  localparam int Depth = 2 * GRID_CELLS + LEVELS + 1;
  localparam int Aw    = $clog2(Depth);

  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StLoad  = 4'd2;
  localparam logic [3:0] StLoad2 = 4'd3;
  localparam logic [3:0] StRead  = 4'd4;
  localparam logic [3:0] StRun   = 4'd5;
  localparam logic [3:0] StRd0   = 4'd6;
  localparam logic [3:0] StRd1   = 4'd7;
  localparam logic [3:0] StRd2   = 4'd8;
  localparam logic [3:0] StRd3   = 4'd9;
  localparam logic [3:0] StWr    = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;
  localparam logic [3:0] StEnds  = 4'd12;
  localparam logic [3:0] StLoad3 = 4'd13;

  logic signed [31:0] fmem [Depth];
  logic signed [31:0] smem [Depth];

  logic [3:0]         st_q, st_d;
  logic [Aw-1:0]      clr_q;
  logic [31:0]        scale_q;
  logic signed [31:0] left_q, right_q;
  logic signed [32:0] prev_q;
  logic signed [32:0] chg_q;
  logic [Aw-1:0]      idx_q;
  logic [7:0]         cnt_q;
  logic signed [31:0] ld_pot_q;
  logic               rsp_vld_q;
  logic signed [31:0] rsp_pot_q;
  logic [8:0]         rsp_idx_q;
  logic               rsp_done_q;
  logic               oor_q;

  logic               f_we, s_we;
  logic [Aw-1:0]      f_wa, s_wa, f_ra, s_ra;
  logic signed [31:0] f_wd, s_wd, f_rd_q, s_rd_q;

  p1mg_pkg::step_t    step;
  logic               seq_next, seq_done, seq_start;
  p1mg_pkg::step_t    cur_q;
  logic signed [31:0] a_q, b_q, c_q;
  logic               src_start;
  logic signed [31:0] src_val;
  logic signed [35:0] upd;
  logic [10:0]        ra_j;
  logic               ra_oob;
  logic               oob_q;
  logic signed [31:0] rdv;

  p1mg_src u_src (
    .clk_i,
    .start_i (src_start),
    .sum_i   (34'(chg_q) + 34'(prev_q)),
    .scale_i (scale_q),
    .src_o   (src_val)
  );

  p1mg_seq #(
    .GRID_CELLS(GRID_CELLS), .LEVELS(LEVELS), .SMOOTH_SWEEPS(SMOOTH_SWEEPS)
  ) u_seq (
    .clk_i, .rst_ni,
    .start_i  (seq_start),
    .cycles_i (cnt_q),
    .next_i   (seq_next),
    .step_o   (step),
    .done_o   (seq_done)
  );

  always_ff @(posedge clk_i) begin
    if (f_we) fmem[f_wa] <= f_wd;
    if (s_we) smem[s_wa] <= s_wd;
    f_rd_q <= fmem[f_ra];
    s_rd_q <= smem[s_ra];
    oob_q  <= ra_oob;
  end

  assign rdv = oob_q ? 32'sd0 : f_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      left_q  <= '0;
      right_q <= p1mg_pkg::RightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        p1mg_pkg::CfgScale: scale_q <= cfg_data_i;
        p1mg_pkg::CfgLeft:  left_q  <= cfg_data_i;
        p1mg_pkg::CfgRight: right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req.ready  = (st_q == StIdle) && !rsp_vld_q;
  assign seq_start  = (st_q == StEnds);
  assign src_start  = (st_q == StLoad);
  assign rsp.valid  = rsp_vld_q;
  assign rsp.potential    = rsp_pot_q;
  assign rsp.result_index = rsp_idx_q;
  assign rsp.solve_done   = rsp_done_q;

  always_comb begin
    f_we = 1'b0; s_we = 1'b0;
    f_wa = idx_q; s_wa = idx_q;
    f_wd = ld_pot_q; s_wd = src_val;
    f_ra = idx_q; s_ra = idx_q;
    ra_j = '0; ra_oob = 1'b0;
    seq_next = 1'b0;
    st_d = st_q;
    upd = '0;
    case (st_q)
      StClr: begin
        f_we = 1'b1; s_we = 1'b1;
        f_wa = clr_q; s_wa = clr_q;
        f_wd = '0; s_wd = '0;
        if (clr_q == Aw'(Depth - 1)) st_d = StIdle;
      end
      StIdle: begin
        f_ra = Aw'(req.point_index);
        if (req.valid && req.ready) begin
          case (req.req_type)
            p1mg_pkg::ReqLoad:
              st_d = (req.point_index <= 9'(GRID_CELLS)) ? StLoad : StIdle;
            p1mg_pkg::ReqRun:  st_d = StEnds;
            p1mg_pkg::ReqRead: st_d = StRead;
            default: st_d = StIdle;
          endcase
        end
      end
      StLoad: st_d = StLoad2;
      StLoad2: st_d = StLoad3;
      StLoad3: begin
        f_we = 1'b1; s_we = 1'b1;
        st_d = StIdle;
      end
      StRead: st_d = StIdle;
      StEnds: begin
        f_we = 1'b1; f_wa = '0; f_wd = left_q;
        st_d = StRun;
      end
      StRun: begin
        f_we = 1'b1; f_wa = Aw'(GRID_CELLS); f_wd = right_q;
        if (seq_done) st_d = StDone;
        else if (step.vld) st_d = StRd0;
      end
      StRd0, StRd1, StRd2, StRd3: begin
        case (cur_q.op)
          p1mg_pkg::OpSmooth: begin
            ra_j = (st_q == StRd0) ? cur_q.j - 11'd1 : cur_q.j + 11'd1;
            ra_oob = ra_j > cur_q.ncells;
            f_ra = Aw'(cur_q.base + ra_j);
            s_ra = Aw'(cur_q.base + cur_q.j);
          end
          p1mg_pkg::OpRestrict: begin
            ra_j = (st_q == StRd0) ? 11'((cur_q.j << 1) - 11'd1) :
                   (st_q == StRd1) ? 11'((cur_q.j << 1) + 11'd1) : 11'(cur_q.j << 1);
            ra_oob = ra_j > cur_q.ncells;
            f_ra = Aw'(cur_q.base + ra_j);
            s_ra = Aw'(cur_q.base + ra_j);
          end
          p1mg_pkg::OpProlEven: begin
            ra_j = (st_q == StRd0) ? (cur_q.j >> 1) : cur_q.j;
            ra_oob = (st_q == StRd0) ? (ra_j > cur_q.ccells) : 1'b0;
            f_ra = (st_q == StRd0) ? Aw'(cur_q.cbase + ra_j) : Aw'(cur_q.base + ra_j);
          end
          default: begin
            ra_j = (st_q == StRd0) ? ((cur_q.j + 11'd1) >> 1) :
                   (st_q == StRd1) ? ((cur_q.j - 11'd1) >> 1) : cur_q.j;
            ra_oob = (st_q == StRd2) ? 1'b0 : (ra_j > cur_q.ccells);
            f_ra = (st_q == StRd2) ? Aw'(cur_q.base + ra_j) : Aw'(cur_q.cbase + ra_j);
          end
        endcase
        st_d = (st_q == StRd3) ? StWr : 4'(st_q + 4'd1);
      end
      StWr: begin
        f_we = 1'b1;
        f_wa = Aw'(cur_q.base + cur_q.j);
        case (cur_q.op)
          p1mg_pkg::OpSmooth: begin
            upd = 36'((36'(a_q) + 36'(b_q)) >>> 1) + 36'(s_rd_q);
            f_wd = p1mg_pkg::sat32(upd);
          end
          p1mg_pkg::OpRestrict: begin
            upd = 36'(4 * 36'(s_rd_q)) - 36'(4 * 36'(rdv)) + 36'(2 * (36'(a_q) + 36'(b_q)));
            f_wa = Aw'(cur_q.cbase + cur_q.j);
            f_wd = '0;
            s_we = 1'b1;
            s_wa = Aw'(cur_q.cbase + cur_q.j);
            s_wd = p1mg_pkg::sat32(upd);
          end
          p1mg_pkg::OpProlEven: begin
            upd = 36'(c_q) + 36'(a_q);
            f_wd = p1mg_pkg::sat32(upd);
          end
          default: begin
            upd = 36'(c_q) + ((36'(a_q) + 36'(b_q)) >>> 1);
            f_wd = p1mg_pkg::sat32(upd);
          end
        endcase
        seq_next = 1'b1;
        st_d = StRun;
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && req.valid && req.ready) begin
      idx_q    <= Aw'(req.point_index);
      cnt_q    <= req.cycle_count;
      ld_pot_q <= req.start_potential;
      chg_q    <= 33'(req.electron_density) - 33'(req.ion_density);
      oor_q    <= req.point_index > 9'(GRID_CELLS);
    end
    if (st_q == StRun) cur_q <= step;
    if (st_q == StRd1) a_q <= rdv;
    if (st_q == StRd2) b_q <= rdv;
    if (st_q == StRd3) c_q <= rdv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StClr;
      clr_q      <= '0;
      prev_q     <= '0;
      rsp_vld_q  <= 1'b0;
      rsp_pot_q  <= '0;
      rsp_idx_q  <= '0;
      rsp_done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClr) clr_q <= clr_q + Aw'(1);
      if (st_q == StLoad3) prev_q <= chg_q;
      if (rsp_vld_q && rsp.ready) rsp_vld_q <= 1'b0;
      if (st_q == StRead) begin
        rsp_vld_q  <= 1'b1;
        rsp_pot_q  <= oor_q ? 32'sd0 : f_rd_q;
        rsp_idx_q  <= 9'(idx_q);
        rsp_done_q <= 1'b0;
      end
      if (st_q == StDone) begin
        rsp_vld_q  <= 1'b1;
        rsp_pot_q  <= '0;
        rsp_idx_q  <= '0;
        rsp_done_q <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |-> (st_q == StIdle))
    else $error("request taken while busy");
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.solve_done) |-> (rsp.potential == 32'sd0))
    else $error("run acknowledge carries data");
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StClr) |-> !req.ready)
    else $error("ready during clearing pass");
`endif
endmodule
`default_nettype wire
